[sv/gmuc_pkg.sv]
// Shared types and constants for the grouped map update cache.
// No dependencies; imported by every module of the block.
package gmuc_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int GROUP_SLOTS_DEF   = 32;
  localparam int MAX_OUT           = 32;
  localparam logic [31:0] FF32     = 32'hFFFF_FFFF;
  localparam logic [3:0] GROUP_SHIFT_RESET = 4'd5;
  localparam logic [3:0] SHIFT_MAX = 4'd10;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_FLUSH  = 3'd2;
  localparam logic [2:0] OP_MAXDIR = 3'd3;
  localparam logic [2:0] OP_MINAGE = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] lpn;
    logic [31:0] new_address;
    logic [15:0] dst_block;
    logic [31:0] meta_age;
  } in_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [9:0]  offset;
    logic [5:0]  count;
    logic [31:0] group_base;
    logic [31:0] min_age;
    logic        last;
    logic        inc_valid;
    logic [15:0] inc_block;
    logic        dec_valid;
    logic [15:0] dec_block;
  } out_res_t;

  typedef struct packed {
    logic [31:0] page;
    logic [31:0] addr;
    logic [15:0] blk;
  } entry_t;

  // slot update request: open stamps base/age, close clears, inc bumps count
  typedef struct packed {
    logic        open;
    logic        close;
    logic        inc;
    logic [31:0] base;
    logic [31:0] age;
  } slot_wr_t;

endpackage

[sv/gmuc_entry_mem.sv]
// Entry table storage: page, address and block per entry.
// One write and one registered read per cycle. Uses gmuc_pkg.
module gmuc_entry_mem #(
  parameter int DEPTH = gmuc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  gmuc_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output gmuc_pkg::entry_t         rdata
);
  import gmuc_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[sv/gmuc_slot_file.sv]
// Group slot registers: base, pending count and first-update age.
// Read at one scan index, updated at one index per cycle. Uses gmuc_pkg.
module gmuc_slot_file #(
  parameter int SLOTS = gmuc_pkg::GROUP_SLOTS_DEF,
  parameter int CW    = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [$clog2(SLOTS)-1:0] ridx,
  output logic [CW-1:0]            rcount,
  output logic [31:0]              rbase,
  output logic [31:0]              rage,
  input  logic [$clog2(SLOTS)-1:0] widx,
  input  gmuc_pkg::slot_wr_t       wr
);
  import gmuc_pkg::*;

  logic [CW-1:0] count_r [SLOTS];
  logic [31:0]   base_r  [SLOTS];
  logic [31:0]   age_r   [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        count_r[i] <= '0;
        base_r[i]  <= '0;
        age_r[i]   <= '0;
      end
    end else begin
      if (wr.open) begin
        base_r[widx] <= wr.base;
        age_r[widx]  <= wr.age;
      end
      if (wr.close) begin
        base_r[widx]  <= '0;
        count_r[widx] <= '0;
      end
      if (wr.inc) begin
        count_r[widx] <= count_r[widx] + CW'(1);
      end
    end
  end

  assign rcount = count_r[ridx];
  assign rbase  = base_r[ridx];
  assign rage   = age_r[ridx];
endmodule

[sv/grouped_map_update_cache.sv]
// Grouped map update cache: sequencer scanning slot registers and entry RAM.
// Add and flush scan slot registers and then entries; search scans only entries;
// queries scan only slots. Flush can also be held by output stalls.
// One request at a time; next request taken the cycle after its result registers.
// Synchronous active-low reset clears slot counts, fill count, state; shift=5.
module grouped_map_update_cache #(
  parameter int TABLE_ENTRIES = gmuc_pkg::TABLE_ENTRIES_DEF,
  parameter int GROUP_SLOTS   = gmuc_pkg::GROUP_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gmuc_pkg::in_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output gmuc_pkg::out_res_t out_res,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);
  import gmuc_pkg::*;

  localparam int EIW = $clog2(TABLE_ENTRIES);
  localparam int ECW = $clog2(TABLE_ENTRIES + 1);
  localparam int SIW = $clog2(GROUP_SLOTS);
  localparam int SCW = $clog2(GROUP_SLOTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SLOT, S_SDEC, S_ERD, S_EEV, S_FIN} state_t;

  state_t     state_r;
  logic [3:0] group_shift_r;
  logic [2:0] op_r;
  logic [31:0] lpn_r, naddr_r, age_r, key_r, mask_r;
  logic [32:0] hi_r;
  logic [15:0] dblk_r;
  logic [SCW-1:0] sidx_r;
  logic [SIW-1:0] hit_slot_r, empty_slot_r;
  logic        match_r, empty_v_r;
  logic [ECW-1:0] mx_r;
  logic [31:0] mxgb_r, mn_r, mngb_r;
  logic [ECW-1:0] used_r, idx_r, hits_r;
  out_res_t    pend_r;
  logic        pend_v_r;
  logic        out_valid_r;
  out_res_t    out_res_r;

  // slot file
  logic [ECW-1:0] s_cnt;
  logic [31:0] s_base, s_age;
  logic [SIW-1:0] s_widx;
  slot_wr_t    s_wr;

  gmuc_slot_file #(.SLOTS(GROUP_SLOTS), .CW(ECW)) u_slots (
    .clk(clk), .rst_n(rst_n), .ridx(sidx_r[SIW-1:0]),
    .rcount(s_cnt), .rbase(s_base), .rage(s_age),
    .widx(s_widx), .wr(s_wr)
  );

  // entry memory
  logic        e_we;
  logic [EIW-1:0] e_waddr;
  entry_t      e_wdata, ent;

  gmuc_entry_mem #(.DEPTH(TABLE_ENTRIES)) u_entries (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(idx_r[EIW-1:0]), .rdata(ent)
  );

  logic out_free, e_match, f_hit, scan_end, s_match, push_blocked, push_out;
  logic [3:0] eff_shift;
  logic slot_ok, table_full;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign eff_shift = (group_shift_r > SHIFT_MAX) ? SHIFT_MAX : group_shift_r;

  assign e_match  = (ent.page == lpn_r);
  assign f_hit    = (ent.page >= lpn_r) && ({1'b0, ent.page} < hi_r);
  assign scan_end = (idx_r == used_r);
  assign s_match  = (s_cnt != '0) && (s_base == key_r);
  assign push_blocked = f_hit && pend_v_r && !out_free;
  assign slot_ok    = match_r || empty_v_r;
  assign table_full = (32'(used_r) >= TABLE_ENTRIES);
  // a new output register load: final request result, or a flush hit displacing pend
  assign push_out = (state_r == S_FIN && out_free) ||
                    (state_r == S_EEV && op_r == OP_FLUSH && f_hit && pend_v_r &&
                     out_free && 32'(hits_r) < MAX_OUT);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = idx_r[EIW-1:0];
    e_wdata = ent;
    s_wr    = '0;
    s_widx  = match_r ? hit_slot_r : empty_slot_r;
    s_wr.base = key_r;
    s_wr.age  = age_r;
    case (state_r)
      S_SDEC: begin
        if (op_r == OP_ADD && slot_ok && !table_full && !match_r) s_wr.open = 1'b1;
        if (op_r == OP_FLUSH && match_r) s_wr.close = 1'b1;
      end
      S_ERD: begin
        if (op_r == OP_ADD && scan_end) begin
          e_we    = 1'b1;
          e_waddr = used_r[EIW-1:0];
          e_wdata = '{page: lpn_r, addr: naddr_r, blk: dblk_r};
          s_wr.inc = 1'b1;
        end
      end
      S_EEV: begin
        if (op_r == OP_ADD && e_match) begin
          e_we    = 1'b1;
          e_wdata = '{page: ent.page, addr: naddr_r, blk: dblk_r};
        end
        if (op_r == OP_FLUSH && !f_hit && hits_r != '0) begin
          e_we    = 1'b1;
          e_waddr = EIW'(idx_r - hits_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      group_shift_r <= GROUP_SHIFT_RESET;
      used_r        <= '0;
      out_valid_r   <= 1'b0;
      pend_v_r      <= 1'b0;
    end else begin
      if (cfg_we) group_shift_r <= cfg_wdata;
      if (push_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_req.opcode;
            lpn_r   <= in_req.lpn;
            naddr_r <= in_req.new_address;
            dblk_r  <= in_req.dst_block;
            age_r   <= in_req.meta_age;
            mask_r  <= (32'd1 << eff_shift) - 32'd1;
            hi_r    <= {1'b0, in_req.lpn} + (33'd1 << eff_shift);
            key_r   <= (in_req.opcode == OP_ADD)
                       ? (in_req.lpn & ~((32'd1 << eff_shift) - 32'd1)) : in_req.lpn;
            sidx_r  <= '0;
            idx_r   <= '0;
            hits_r  <= '0;
            match_r <= 1'b0;
            empty_v_r <= 1'b0;
            mx_r    <= '0;
            mxgb_r  <= FF32;
            mn_r    <= FF32;
            mngb_r  <= '0;
            pend_r  <= '0;
            pend_v_r <= 1'b0;
            case (in_req.opcode)
              OP_ADD, OP_FLUSH, OP_MAXDIR, OP_MINAGE: state_r <= S_SLOT;
              OP_SEARCH: state_r <= S_ERD;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SLOT: begin
          if (32'(sidx_r) == GROUP_SLOTS) begin
            state_r <= S_SDEC;
          end else if ((op_r == OP_ADD || op_r == OP_FLUSH) && s_match) begin
            match_r    <= 1'b1;
            hit_slot_r <= sidx_r[SIW-1:0];
            state_r    <= S_SDEC;
          end else begin
            if (!empty_v_r && s_cnt == '0) begin
              empty_v_r    <= 1'b1;
              empty_slot_r <= sidx_r[SIW-1:0];
            end
            if (s_cnt > mx_r) begin
              mx_r   <= s_cnt;
              mxgb_r <= s_base;
            end
            if (s_cnt != '0 && s_age < mn_r) begin
              mn_r   <= s_age;
              mngb_r <= s_base;
            end
            sidx_r <= sidx_r + SCW'(1);
          end
        end
        S_SDEC: begin
          case (op_r)
            OP_ADD: begin
              if (!slot_ok || table_full) begin
                pend_r  <= '0;
                state_r <= S_FIN;
              end else begin
                sidx_r  <= SCW'(s_widx);
                state_r <= S_ERD;
              end
            end
            OP_FLUSH: state_r <= S_ERD;
            OP_MAXDIR: begin
              pend_r.ok         <= (mx_r != '0);
              pend_r.count      <= 6'(mx_r);
              pend_r.group_base <= mxgb_r;
              state_r <= S_FIN;
            end
            default: begin
              pend_r.ok         <= (mn_r != FF32);
              pend_r.min_age    <= mn_r;
              pend_r.group_base <= mngb_r;
              state_r <= S_FIN;
            end
          endcase
        end
        S_ERD: begin
          if (scan_end) begin
            state_r <= S_FIN;
            case (op_r)
              OP_ADD: begin
                used_r <= used_r + ECW'(1);
                pend_r.ok        <= 1'b1;
                pend_r.inc_valid <= 1'b1;
                pend_r.inc_block <= dblk_r;
              end
              OP_SEARCH: pend_r.address <= FF32;
              default: begin
                used_r <= used_r - hits_r;
                if (pend_v_r) pend_r.last <= 1'b1;
                else pend_r <= '{last: 1'b1, default: '0};
              end
            endcase
          end else begin
            state_r <= S_EEV;
          end
        end
        S_EEV: begin
          if (op_r == OP_FLUSH) begin
            if (!push_blocked) begin
              if (f_hit) begin
                hits_r <= hits_r + ECW'(1);
                // hits past MAX_OUT are removed but not reported
                if (32'(hits_r) < MAX_OUT) begin
                  if (pend_v_r) out_res_r <= pend_r;
                  pend_r <= '{ok: 1'b1, address: ent.addr,
                              offset: 10'(ent.page & mask_r),
                              count: 6'(hits_r + ECW'(1)), default: '0};
                  pend_v_r <= 1'b1;
                end
              end
              idx_r   <= idx_r + ECW'(1);
              state_r <= S_ERD;
            end
          end else if (e_match) begin
            state_r <= S_FIN;
            pend_r.ok <= 1'b1;
            if (op_r == OP_SEARCH) begin
              pend_r.address <= ent.addr;
            end else if (ent.blk != dblk_r) begin
              pend_r.inc_valid <= 1'b1;
              pend_r.inc_block <= dblk_r;
              pend_r.dec_valid <= 1'b1;
              pend_r.dec_block <= ent.blk;
            end
          end else begin
            idx_r   <= idx_r + ECW'(1);
            state_r <= S_ERD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_res_r   <= pend_r;
            pend_v_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= TABLE_ENTRIES)
    else $error("entry fill count beyond table depth");

  a_hits_le_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERD && op_r == OP_FLUSH) |-> hits_r <= idx_r)
    else $error("flush hits exceed scanned entries");

  a_fin_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("final request result not delivered");

endmodule
